FILE: sv/if5_pkg.sv
`default_nettype none
package if5_pkg;

    localparam int PIX_W   = 8;
    localparam int COL_W   = 11;
    localparam int ROW_W   = 14;
    localparam int COEF_W  = 12;
    localparam int TAPS    = 5;
    localparam int CFG_W   = 60;
    localparam int IDX_W   = 3;
    localparam int BIAS_W  = 20;
    localparam int FW_W    = 12;
    localparam int FH_W    = 14;
    localparam int PROD_W  = 21;
    localparam int SUM_W   = 28;

    localparam logic [IDX_W-1:0] REG_COEF0  = 3'd0;
    localparam logic [IDX_W-1:0] REG_COEF1  = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEF2  = 3'd2;
    localparam logic [IDX_W-1:0] REG_COEF3  = 3'd3;
    localparam logic [IDX_W-1:0] REG_COEF4  = 3'd4;
    localparam logic [IDX_W-1:0] REG_BIAS   = 3'd5;
    localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd6;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd7;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             frame_start;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic [COL_W-1:0] out_col;
        logic [ROW_W-1:0] out_row;
        logic             run_last;
    } out_item_t;

    // One classified pixel handed from the front part to the filter part.
    typedef struct packed {
        logic [PIX_W-1:0]           pix;
        logic [COL_W-1:0]           col;
        logic [ROW_W-1:0]           row;
        logic                       interior;
        logic                       border;
        logic [TAPS*TAPS*PIX_W-1:0] win;
    } task_t;

endpackage
`default_nettype wire

FILE: sv/if5_front.sv
`default_nettype none
module if5_front
    import if5_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire in_item_t         in_item,
    input  wire logic [FW_W-1:0]  frame_width,
    input  wire logic [FH_W-1:0]  frame_height,
    output logic                  task_valid,
    input  wire logic             task_ready,
    output task_t                 task_out
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = AW + 1;

    // Stage 1: position and line store read; stage 2: window shift and classify.
    logic [CW-1:0]     col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [CW-1:0]     w_eff;
    logic [ROW_W-1:0]  h_eff;
    logic [CW-1:0]     c_pre, c_now;
    logic [ROW_W-1:0]  r_pre, r_now;
    logic [31:0]       mem [MAX_WIDTH];
    logic [31:0]       rd_reg;
    logic              s1_valid_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic [CW-1:0]     s1_col_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [31:0]       fwd_reg;
    logic              fwd_hit_reg;
    logic [31:0]       old_word;
    logic [PIX_W-1:0]  win_reg [TAPS][TAPS];
    logic              t_valid_reg;
    task_t             t_reg;
    logic              adv, take;

    always_comb begin
        if (frame_width < FW_W'(5)) w_eff = CW'(5);
        else if (32'(frame_width) > 32'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
        else w_eff = CW'(frame_width);
        h_eff = (frame_height < FH_W'(5)) ? ROW_W'(5) : frame_height;
        c_pre = in_item.frame_start ? '0 : col_reg;
        r_pre = in_item.frame_start ? '0 : row_reg;
        if (c_pre >= w_eff) begin
            c_now = '0;
            r_now = r_pre + 1'b1;
        end else begin
            c_now = c_pre;
            r_now = r_pre;
        end
        if (r_now >= h_eff) r_now = '0;
    end

    assign adv     = !t_valid_reg || task_ready;
    assign in_ready = adv;
    assign take    = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (adv) s1_valid_reg <= take;
            if (take) begin
                if (c_now + 1'b1 >= w_eff) begin
                    col_reg <= '0;
                    row_reg <= (r_now + 1'b1 >= h_eff) ? '0 : r_now + 1'b1;
                end else begin
                    col_reg <= c_now + 1'b1;
                    row_reg <= r_now;
                end
            end
        end
    end

    // Write-back of the previous pixel happens as it leaves stage 1, in the cycle of
    // the next read if one is taken then. When the very next pixel reads the same column,
    // which happens when a frame start follows a pixel in column 0, the new word is forwarded.
    assign old_word = fwd_hit_reg ? fwd_reg : rd_reg;

    always_ff @(posedge aclk) begin
        if (take) begin
            rd_reg     <= mem[c_now[AW-1:0]];
            s1_pix_reg <= in_item.pixel_in;
            s1_col_reg <= c_now;
            s1_row_reg <= r_now;
            fwd_hit_reg <= s1_valid_reg && adv && (s1_col_reg == c_now);
        end
        if (adv && s1_valid_reg) begin
            mem[s1_col_reg[AW-1:0]] <= {old_word[23:0], s1_pix_reg};
            fwd_reg <= {old_word[23:0], s1_pix_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_valid_reg <= 1'b0;
            for (int i = 0; i < TAPS; i++)
                for (int j = 0; j < TAPS; j++)
                    win_reg[i][j] <= '0;
        end else if (adv) begin
            t_valid_reg <= s1_valid_reg;
            if (s1_valid_reg) begin
                for (int i = 0; i < TAPS; i++)
                    for (int j = 0; j < TAPS-1; j++)
                        win_reg[i][j] <= win_reg[i][j+1];
                win_reg[0][4] <= old_word[31:24];
                win_reg[1][4] <= old_word[23:16];
                win_reg[2][4] <= old_word[15:8];
                win_reg[3][4] <= old_word[7:0];
                win_reg[4][4] <= s1_pix_reg;
                t_reg.pix <= s1_pix_reg;
                t_reg.col <= COL_W'(s1_col_reg);
                t_reg.row <= s1_row_reg;
                t_reg.interior <= (s1_col_reg >= CW'(4)) && (s1_row_reg >= ROW_W'(4));
                t_reg.border <= (s1_col_reg < CW'(2)) || (s1_col_reg >= w_eff - CW'(2))
                             || (s1_row_reg < ROW_W'(2)) || (s1_row_reg >= h_eff - ROW_W'(2));
            end
        end
    end

    // Window as seen after the shift, packed row-major.
    always_comb begin
        task_out.pix      = t_reg.pix;
        task_out.col      = t_reg.col;
        task_out.row      = t_reg.row;
        task_out.interior = t_reg.interior;
        task_out.border   = t_reg.border;
        for (int i = 0; i < TAPS; i++)
            for (int j = 0; j < TAPS; j++)
                task_out.win[(i*TAPS+j)*PIX_W +: PIX_W] = win_reg[i][j];
    end
    assign task_valid = t_valid_reg;

endmodule
`default_nettype wire

FILE: sv/if5_fifo.sv
`default_nettype none
module if5_fifo
    import if5_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  wr_valid,
    output logic       wr_ready,
    input  wire task_t wr_data,
    output logic       rd_valid,
    input  wire logic  rd_ready,
    output task_t      rd_data
);
    // Two-entry queue between the window front and the filter back.
    task_t       buf_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    logic        wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = buf_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) buf_reg[wp_reg] <= wr_data;
    end

endmodule
`default_nettype wire

FILE: sv/if5_back.sv
`default_nettype none
module if5_back
    import if5_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   t_valid,
    output logic                        t_ready,
    input  wire task_t                  t_data,
    input  wire logic [TAPS*CFG_W-1:0]  coefs,
    input  wire logic [BIAS_W-1:0]      bias,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output out_item_t                   m_item
);
    // Stage A: 25 products. Stage B: row sums. Stage C: total, round, clamp.
    // The output emitter works on the stage C registers and may send none, one or two items for one pixel.
    logic               adv;
    logic               a_v_reg, b_v_reg, c_v_reg;
    task_t              a_t_reg, b_t_reg;
    logic signed [PROD_W-1:0] prod_reg [TAPS][TAPS];
    logic signed [SUM_W-1:0]  rsum_reg [TAPS];
    logic signed [SUM_W-1:0]  rs_next [TAPS];
    logic signed [SUM_W-1:0]  tot;
    logic [PIX_W-1:0]   filt;
    task_t              c_t_reg;
    logic [PIX_W-1:0]   c_f_reg;
    logic               pend_reg;   // interior item sent, border item still owed
    logic               last_slot;

    always_comb begin
        for (int k = 0; k < TAPS; k++) begin
            rs_next[k] = '0;
            for (int j = 0; j < TAPS; j++)
                rs_next[k] = rs_next[k] + SUM_W'(prod_reg[k][j]);
        end
        tot = SUM_W'($signed(bias)) + SUM_W'(1 <<< (COEF_FRAC_BITS-1));
        for (int k = 0; k < TAPS; k++) tot = tot + rsum_reg[k];
        if (tot < 0) filt = '0;
        else if ((tot >>> COEF_FRAC_BITS) > SUM_W'(255)) filt = 8'd255;
        else filt = PIX_W'(tot >>> COEF_FRAC_BITS);
    end

    // The emitter holds a pixel that owes two items until both have been taken.
    assign last_slot = !(c_t_reg.interior && c_t_reg.border) || pend_reg;
    assign adv     = !c_v_reg || (m_ready && last_slot) || (!c_t_reg.interior && !c_t_reg.border);
    assign t_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            pend_reg <= 1'b0;
        end else begin
            if (adv) begin
                a_v_reg <= t_valid;
                b_v_reg <= a_v_reg;
                c_v_reg <= b_v_reg;
                pend_reg <= 1'b0;
            end else if (c_v_reg && m_ready) begin
                pend_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_t_reg <= t_data;
            for (int k = 0; k < TAPS; k++)
                for (int j = 0; j < TAPS; j++)
                    prod_reg[k][j] <= PROD_W'($signed({1'b0,
                        t_data.win[((TAPS-1-k)*TAPS+j)*PIX_W +: PIX_W]}))
                        * PROD_W'($signed(coefs[k*CFG_W + j*COEF_W +: COEF_W]));
            b_t_reg <= a_t_reg;
            for (int k = 0; k < TAPS; k++) rsum_reg[k] <= rs_next[k];
            c_t_reg <= b_t_reg;
            c_f_reg <= filt;
        end
    end

    assign m_valid = c_v_reg && (c_t_reg.interior || c_t_reg.border);
    always_comb begin
        if (c_t_reg.interior && !pend_reg) begin
            m_item.pixel_out = c_f_reg;
            m_item.out_col   = c_t_reg.col - COL_W'(2);
            m_item.out_row   = c_t_reg.row - ROW_W'(2);
            m_item.run_last  = !c_t_reg.border;
        end else begin
            m_item.pixel_out = c_t_reg.pix;
            m_item.out_col   = c_t_reg.col;
            m_item.out_row   = c_t_reg.row;
            m_item.run_last  = 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_pend_both: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (c_v_reg && c_t_reg.interior && c_t_reg.border))
        else $error("second item owed without a two-item pixel");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped under stall");
    a_first_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && c_t_reg.interior && c_t_reg.border && !pend_reg) |-> !m_item.run_last)
        else $error("first of two items flagged last");
`endif

endmodule
`default_nettype wire

FILE: sv/image_filter_5x5_u8_core.sv
`default_nettype none
// Path: an item's results appear after it passes two front stages, the queue and
// three filter stages; an interior result comes with the pixel two lines and two
// columns later. Throughput: one item per cycle while m_ready is high, except that a
// pixel giving two results holds the output port until both are taken.
// Reset: aresetn is synchronous, active low; it clears control state and the window
// and loads the configuration defaults; data registers and the line store are not cleared.
module image_filter_5x5_u8_core
    import if5_pkg::*;
#(
    parameter int MAX_WIDTH      = 2048,
    parameter int COEF_FRAC_BITS = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_item_t          s_item,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_item_t              m_item,
    input  wire logic              cfg_we,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data
);
    // Configuration registers. The identity kernel has the centre tap at 1.0.
    logic [TAPS*CFG_W-1:0] coef_reg;
    logic [BIAS_W-1:0]     bias_reg;
    logic [FW_W-1:0]       width_reg;
    logic [FH_W-1:0]       height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg   <= {{(TAPS*CFG_W-1){1'b0}}, 1'b1}
                          << (2*CFG_W + 2*COEF_W + COEF_FRAC_BITS);
            bias_reg   <= '0;
            width_reg  <= FW_W'(640);
            height_reg <= FH_W'(480);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_COEF0:  coef_reg[0*CFG_W +: CFG_W] <= cfg_data;
                REG_COEF1:  coef_reg[1*CFG_W +: CFG_W] <= cfg_data;
                REG_COEF2:  coef_reg[2*CFG_W +: CFG_W] <= cfg_data;
                REG_COEF3:  coef_reg[3*CFG_W +: CFG_W] <= cfg_data;
                REG_COEF4:  coef_reg[4*CFG_W +: CFG_W] <= cfg_data;
                REG_BIAS:   bias_reg   <= cfg_data[BIAS_W-1:0];
                REG_WIDTH:  width_reg  <= cfg_data[FW_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    task_t f_data, q_data;
    logic  f_valid, f_ready, q_valid, q_ready;

    // The front part keeps the line store and window and tags each pixel.
    if5_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_item(s_item),
        .frame_width(width_reg), .frame_height(height_reg),
        .task_valid(f_valid), .task_ready(f_ready), .task_out(f_data)
    );

    // A short queue lets the filter stall without stopping the front at once.
    if5_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
    );

    // The back part multiplies, sums, rounds, clamps and emits results.
    if5_back #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .t_valid(q_valid), .t_ready(q_ready), .t_data(q_data),
        .coefs(coef_reg), .bias(bias_reg),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

endmodule
`default_nettype wire
